FILE: design/afb_pkg.sv
// afb_pkg: shared constants, codes and types of the astm frame builder
// used by afb_seq and astm_frame_builder; depends on nothing
`default_nettype none

package afb_pkg;

   // control characters of the line stream
   localparam logic [7:0] CHAR_STX = 8'h02;
   localparam logic [7:0] CHAR_ETX = 8'h03;
   localparam logic [7:0] CHAR_ETB = 8'h17;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   // input item kinds
   localparam logic [1:0] OP_DATA   = 2'd0;
   localparam logic [1:0] OP_EOR    = 2'd1;
   localparam logic [1:0] OP_NEWMSG = 2'd2;

   localparam logic [7:0] LIMIT_RESET = 8'd240;

   // byte slots of one item's output, in emission order
   localparam int NUM_SLOTS = 9;

   typedef enum logic [3:0] {
      SLOT_STX    = 4'd0,
      SLOT_DIGIT  = 4'd1,
      SLOT_DATA   = 4'd2,
      SLOT_CR1    = 4'd3,
      SLOT_TERM   = 4'd4,
      SLOT_HEX_HI = 4'd5,
      SLOT_HEX_LO = 4'd6,
      SLOT_CR2    = 4'd7,
      SLOT_LF     = 4'd8
   } slot_type;

   // bytes an item emits, one mask bit per slot
   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [7:0]           digit;
      logic [7:0]           data;
      logic [7:0]           term;
      logic [7:0]           csum;
   } plan_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = CHAR_ZERO + {4'd0, nib};
      end else begin
         res = CHAR_UPPER_A + {4'd0, nib} - 8'd10;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: design/afb_seq.sv
// afb_seq: output sequencer, holds one item's byte plan and sends it a byte a cycle while rsp_tready is high
// depends on afb_pkg
`default_nettype none

module afb_seq import afb_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire plan_type   plan,
   output logic            can_load,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast
);

   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   plan_type             plan_ff, plan_in;
   slot_type             slot;
   logic                 take;
   logic                 is_last;

   assign rsp_tvalid = |mask_ff;
   assign take       = rsp_tvalid && rsp_tready;
   assign is_last    = (mask_ff & (mask_ff - NUM_SLOTS'(1))) == '0;
   assign rsp_tlast  = is_last;
   assign can_load   = !rsp_tvalid || (take && is_last);

   // lowest pending slot
   always_comb begin
      slot = SLOT_STX;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            slot = slot_type'(4'(i));
         end
      end
   end

   always_comb begin
      case (slot)
         SLOT_STX:    rsp_tdata = CHAR_STX;
         SLOT_DIGIT:  rsp_tdata = plan_ff.digit;
         SLOT_DATA:   rsp_tdata = plan_ff.data;
         SLOT_CR1:    rsp_tdata = CHAR_CR;
         SLOT_TERM:   rsp_tdata = plan_ff.term;
         SLOT_HEX_HI: rsp_tdata = hex_char(plan_ff.csum[7:4]);
         SLOT_HEX_LO: rsp_tdata = hex_char(plan_ff.csum[3:0]);
         SLOT_CR2:    rsp_tdata = CHAR_CR;
         SLOT_LF:     rsp_tdata = CHAR_LF;
         default:     rsp_tdata = CHAR_LF;
      endcase
   end

   always_comb begin
      mask_in = mask_ff;
      plan_in = plan_ff;
      if (take) begin
         mask_in = mask_ff & (mask_ff - NUM_SLOTS'(1));
      end
      if (load) begin
         mask_in = plan.mask;
         plan_in = plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      plan_ff <= plan_in;
   end

endmodule

`default_nettype wire

FILE: design/astm_frame_builder.sv
// astm_frame_builder: top level, frames record bytes into astm low-level frames
// depends on afb_pkg and afb_seq
`default_nettype none

// channel   dir  handshake               payload
// req       in   req_tvalid/req_tready   tdata: data_byte  tuser: op
// rsp       out  rsp_tvalid/rsp_tready   tdata: out_byte   tlast: last
// csr       in   csr_valid/csr_ready     csr_data: frame_data_limit
//
// when an item is taken, its frame state registers are updated and its
// 0 to 9 output bytes are planned into the sequencer register
// the sequencer sends one byte per cycle while rsp_tready is high
// the next item is taken in the cycle its predecessor's last byte leaves
// synchronous active-high reset: limit 240, frame number 0, no frame open
// a stalled rsp side holds its byte; csr writes are always taken

module astm_frame_builder import afb_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   // input items
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic [1:0] req_tuser,   // [1:0] op
   // result items
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,   // last
   // configuration
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data     // [7:0] frame_data_limit
);

   logic [7:0] limit_ff, limit_in;
   logic [2:0] num_ff, num_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] cnt_ff, cnt_in;
   logic       open_ff, open_in;

   logic       accept;
   logic       can_load;
   plan_type   plan;

   // working values of the item
   logic [7:0] lim_eff;
   logic [2:0] num_open;
   logic [7:0] digit;
   logic [7:0] sum_base;
   logic [7:0] cnt_base;
   logic [7:0] sum_data;
   logic [7:0] cnt_data;
   logic       close_etb;

   assign csr_ready  = 1'b1;
   assign req_tready = can_load;
   assign accept     = req_tvalid && req_tready;

   assign limit_in = (csr_valid && csr_ready) ? csr_data : limit_ff;

   // a zero limit closes after every byte
   assign lim_eff  = (limit_ff == 8'd0) ? 8'd1 : limit_ff;
   assign num_open = num_ff + 3'd1;
   assign digit    = CHAR_ZERO + {5'd0, num_open};

   // an item that finds no frame open starts one
   assign sum_base  = open_ff ? sum_ff : digit;
   assign cnt_base  = open_ff ? cnt_ff : 8'd0;
   assign sum_data  = sum_base + req_tdata;
   assign cnt_data  = cnt_base + 8'd1;
   assign close_etb = cnt_data >= lim_eff;

   always_comb begin
      num_in     = num_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      open_in    = open_ff;
      plan.mask  = '0;
      plan.digit = digit;
      plan.data  = req_tdata;
      plan.term  = CHAR_ETX;
      plan.csum  = sum_base + CHAR_CR + CHAR_ETX;
      if (accept) begin
         case (req_tuser)
            OP_DATA: begin
               plan.mask[SLOT_DATA] = 1'b1;
               if (!open_ff) begin
                  plan.mask[SLOT_STX]   = 1'b1;
                  plan.mask[SLOT_DIGIT] = 1'b1;
                  num_in                = num_open;
               end
               plan.term = CHAR_ETB;
               plan.csum = sum_data + CHAR_CR + CHAR_ETB;
               if (close_etb) begin
                  plan.mask[SLOT_CR1]    = 1'b1;
                  plan.mask[SLOT_TERM]   = 1'b1;
                  plan.mask[SLOT_HEX_HI] = 1'b1;
                  plan.mask[SLOT_HEX_LO] = 1'b1;
                  plan.mask[SLOT_CR2]    = 1'b1;
                  plan.mask[SLOT_LF]     = 1'b1;
                  sum_in  = 8'd0;
                  cnt_in  = 8'd0;
                  open_in = 1'b0;
               end else begin
                  sum_in  = sum_data;
                  cnt_in  = cnt_data;
                  open_in = 1'b1;
               end
            end
            OP_EOR: begin
               // end of record with no open frame sends an empty frame
               if (!open_ff) begin
                  plan.mask[SLOT_STX]   = 1'b1;
                  plan.mask[SLOT_DIGIT] = 1'b1;
                  num_in                = num_open;
               end
               plan.mask[SLOT_CR1]    = 1'b1;
               plan.mask[SLOT_TERM]   = 1'b1;
               plan.mask[SLOT_HEX_HI] = 1'b1;
               plan.mask[SLOT_HEX_LO] = 1'b1;
               plan.mask[SLOT_CR2]    = 1'b1;
               plan.mask[SLOT_LF]     = 1'b1;
               sum_in  = 8'd0;
               cnt_in  = 8'd0;
               open_in = 1'b0;
            end
            OP_NEWMSG: begin
               // open frame dropped silently
               num_in  = 3'd0;
               sum_in  = 8'd0;
               cnt_in  = 8'd0;
               open_in = 1'b0;
            end
            default: begin
               // unused code: no bytes, state kept
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         num_ff   <= 3'd0;
         sum_ff   <= 8'd0;
         cnt_ff   <= 8'd0;
         open_ff  <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         num_ff   <= num_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         open_ff  <= open_in;
      end
   end

   // byte sequencer, also the output register
   afb_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .plan       (plan),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a data byte always produces output
   a_data_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == OP_DATA) |=> rsp_tvalid)
      else $error("data item produced no output");

   // closed frame leaves no partial sum or count behind
   a_closed_clean: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> (sum_ff == 8'd0 && cnt_ff == 8'd0))
      else $error("stale frame state with no frame open");

   // an empty sequencer never blocks the input
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with sequencer empty");

   // end of record always ends its output with lf
   a_eor_lf: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && $past(accept) && $past(req_tuser) == OP_EOR)
      |-> rsp_tdata == CHAR_LF)
      else $error("end of record output not closed by lf");

endmodule

`default_nettype wire

FILE: verif/astm_frame_builder_tb.sv
// astm_frame_builder_tb: self-checking bench for the astm frame builder
// directed table then random phases, every output byte checked against the local frame predictor or typed bytes
// depends on afb_pkg and astm_frame_builder
`timescale 1ns / 1ps

module astm_frame_builder_tb;
   import afb_pkg::*;

   // op 3 has no meaning to the block, it must be swallowed silently
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 180;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int LONG_HOLD     = 300;    // one long rsp stall to back the block up
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;

   typedef enum logic {
      ROW_ITEM,
      ROW_CFG
   } row_kind_type;

   // one line of stimulus; typed_n > 0 means the expected bytes are given by hand
   typedef struct {
      row_kind_type     kind;
      logic [1:0]       op;
      logic [7:0]       val;        // data byte, or the frame limit for a cfg row
      int               typed_n;
      logic [0:8][7:0]  typed;      // first byte on the left
   } stim_row_type;

   // one expected byte of the framed line stream
   typedef struct {
      logic [7:0] ch;
      logic       last;
   } line_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;    // [7:0] data_byte
   logic [1:0] req_tuser = OP_DATA; // [1:0] op
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // last
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'd0;     // [7:0] frame_data_limit

   // frame state as the predictor sees it
   logic [7:0] fb_limit;
   logic [2:0] fb_frame_num;
   logic [7:0] fb_sum;
   logic [7:0] fb_count;
   logic       fb_open;

   logic [7:0]    line_bytes[$];       // bytes predicted for the item just taken
   line_byte_type line_expect_q[$];    // bytes still owed by the block
   stim_row_type  stim_tbl[$];
   string         hex_chars = "0123456789ABCDEF";

   int  bad_bytes = 0;
   int  cycle_count = 0;
   bit  quiet_run = 1'b0;           // both sides run without gaps
   bit  long_hold_req = 1'b0;

   astm_frame_builder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("astm_frame_builder_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   // STX and the frame digit; the number wraps 7 -> 0
   function automatic void open_frame_bytes();
      fb_frame_num = fb_frame_num + 3'd1;
      line_bytes.push_back(CHAR_STX);
      line_bytes.push_back(CHAR_ZERO + {5'd0, fb_frame_num});
      fb_sum   = CHAR_ZERO + {5'd0, fb_frame_num};
      fb_count = 8'd0;
      fb_open  = 1'b1;
   endfunction

   // CR, ETB or ETX, checksum as two hex chars, CR LF
   function automatic void close_frame_bytes(input logic [7:0] term);
      logic [7:0] s;
      s = fb_sum + CHAR_CR + term;
      line_bytes.push_back(CHAR_CR);
      line_bytes.push_back(term);
      line_bytes.push_back(hex_chars[s[7:4]]);
      line_bytes.push_back(hex_chars[s[3:0]]);
      line_bytes.push_back(CHAR_CR);
      line_bytes.push_back(CHAR_LF);
      fb_sum   = 8'd0;
      fb_count = 8'd0;
      fb_open  = 1'b0;
   endfunction

   function automatic void build_line_bytes(input logic [1:0] op, input logic [7:0] b);
      logic [7:0] lim;
      lim = (fb_limit == 8'd0) ? 8'd1 : fb_limit;
      line_bytes.delete();
      case (op)
         OP_DATA: begin
            if (!fb_open) open_frame_bytes();
            line_bytes.push_back(b);
            fb_sum   = fb_sum + b;
            fb_count = fb_count + 8'd1;
            if (fb_count >= lim) close_frame_bytes(CHAR_ETB);
         end
         OP_EOR: begin
            // an end of record with nothing open still sends an empty frame
            if (!fb_open) open_frame_bytes();
            close_frame_bytes(CHAR_ETX);
         end
         OP_NEWMSG: begin
            // open frame is dropped without output
            fb_frame_num = 3'd0;
            fb_sum       = 8'd0;
            fb_count     = 8'd0;
            fb_open      = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- req side

   task automatic send_record_item(input stim_row_type row);
      int gap;
      gap = quiet_run ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.op;
      req_tdata  <= row.val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // item taken at this edge
      build_line_bytes(row.op, row.val);
      if (row.typed_n > 0) begin
         line_bytes.delete();
         for (int i = 0; i < row.typed_n; i++) line_bytes.push_back(row.typed[i]);
      end
      foreach (line_bytes[i]) begin
         line_expect_q.push_back(line_byte_type'{line_bytes[i], i == line_bytes.size() - 1});
      end
   endtask

   // limit writes happen only with the block drained
   task automatic write_frame_limit(input logic [7:0] lim);
      req_tvalid <= 1'b0;
      while (line_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= lim;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      fb_limit = lim;
   endtask

   // ---------------------------------------------------------------- rsp side

   task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                input logic [7:0] got_v);
      bad_bytes++;
      if (bad_bytes <= MAX_REPORTS) begin
         $display("rsp mismatch on %s: expected %02h got %02h", what, exp_v, got_v);
      end
   endtask

   task automatic check_line_byte(input logic [7:0] ch, input logic last);
      line_byte_type e;
      if (line_expect_q.size() == 0) begin
         note_mismatch("unexpected item, out_byte", 8'h00, ch);
      end else begin
         e = line_expect_q.pop_front();
         if (ch !== e.ch) note_mismatch("out_byte", e.ch, ch);
         if (last !== e.last) note_mismatch("last", {7'd0, e.last}, {7'd0, last});
      end
   endtask

   initial begin : rsp_side
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            gap = LONG_HOLD;
         end else begin
            gap = quiet_run ? 0 : $urandom_range(0, 7);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_line_byte(rsp_tdata, rsp_tlast);
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      stim_row_type row;
      logic [7:0]   lim;
      int           items_sent;
      int           phase;
      int           n;
      int           r;

      fb_limit     = LIMIT_RESET;
      fb_frame_num = 3'd0;
      fb_sum       = 8'd0;
      fb_count     = 8'd0;
      fb_open      = 1'b0;
      items_sent   = 0;
      phase        = 0;

      // empty frame right after reset: digit 1, sum 31+0D+03 = 41
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_EOR, 8'h00, 8,
         {CHAR_STX, "1", CHAR_CR, CHAR_ETX, "41", CHAR_CR, CHAR_LF, 8'h00}});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h00, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'hFF, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_UNUSED, 8'h5A, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h80, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_EOR, 8'h00, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_NEWMSG, 8'h00, 0, '0});
      // new message in the middle of an open frame drops it
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h41, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_NEWMSG, 8'h00, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_CFG, OP_DATA, 8'd1, 0, '0});
      // limit 1: the longest output, sum 31+AA+0D+17 = FF
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'hAA, 9,
         {CHAR_STX, "1", 8'hAA, CHAR_CR, CHAR_ETB, "FF", CHAR_CR, CHAR_LF}});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h7F, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_EOR, 8'h00, 0, '0});
      // a zero limit behaves as one
      stim_tbl.push_back(stim_row_type'{ROW_CFG, OP_DATA, 8'd0, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h00, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'hFF, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_CFG, OP_DATA, 8'd255, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h13, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h0D, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_EOR, 8'h00, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_EOR, 8'h00, 0, '0});
      // frame number wraps to 0: sum 30+0D+03 = 40
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_EOR, 8'h00, 8,
         {CHAR_STX, "0", CHAR_CR, CHAR_ETX, "40", CHAR_CR, CHAR_LF, 8'h00}});
      stim_tbl.push_back(stim_row_type'{ROW_CFG, OP_DATA, 8'd3, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h10, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h20, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_DATA, 8'h30, 0, '0});
      stim_tbl.push_back(stim_row_type'{ROW_ITEM, OP_EOR, 8'h00, 0, '0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_tbl[i]) begin
         if (stim_tbl[i].kind == ROW_CFG) begin
            write_frame_limit(stim_tbl[i].val);
         end else begin
            send_record_item(stim_tbl[i]);
         end
      end

      // random phases, each under its own limit; small limits close frames often
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: lim = 8'd0;
            1: lim = $urandom_range(0, 1) ? 8'd255 : LIMIT_RESET;
            2: lim = 8'($urandom_range(0, 255));
            default: lim = 8'($urandom_range(1, 6));
         endcase
         write_frame_limit(lim);
         quiet_run = ($urandom_range(0, 3) == 0);
         if (phase == 1) long_hold_req = 1'b1;
         n = $urandom_range(12, 30);
         repeat (n) begin
            r = $urandom_range(0, 99);
            row.kind    = ROW_ITEM;
            row.typed_n = 0;
            row.typed   = '0;
            row.val     = 8'($urandom_range(0, 255));
            if (r < 76) begin
               row.op = OP_DATA;
            end else if (r < 91) begin
               row.op = OP_EOR;
            end else if (r < 96) begin
               row.op = OP_NEWMSG;
            end else begin
               row.op = OP_UNUSED;
            end
            send_record_item(row);
            if (row.op != OP_UNUSED) items_sent++;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (line_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_bytes == 0) begin
         $display("astm_frame_builder_tb: done, clean");
      end else begin
         $display("astm_frame_builder_tb: done, errors");
      end
      $finish;
   end

endmodule
